@@ rtl/core/cms_pkg.sv @@
// Shared constants and types for the count-min sketch.
`default_nettype none

package cms_pkg;

  localparam int ROWS_DEFAULT        = 4;
  localparam int COLUMN_BITS_DEFAULT = 10;
  localparam int COUNT_W             = 32;
  localparam int KEY_W               = 32;

  // Configuration register indexes and reset values.
  localparam logic [0:0] CFG_INDEX_BITS  = 1'b0;
  localparam logic [0:0] CFG_ROWS_IN_USE = 1'b1;
  localparam logic [3:0] INDEX_BITS_RESET  = 4'd10;
  localparam logic [2:0] ROWS_IN_USE_RESET = 3'd4;

  // Operation codes carried on in_tuser.
  localparam logic FUNC_ADD      = 1'b0;
  localparam logic FUNC_ESTIMATE = 1'b1;

  // 32-bit mixing hash constants.
  localparam logic [31:0] HASH_C1   = 32'hcc9e2d51;
  localparam logic [31:0] HASH_C2   = 32'h1b873593;
  localparam logic [31:0] HASH_M5   = 32'd5;
  localparam logic [31:0] HASH_N    = 32'he6546b64;
  localparam logic [31:0] HASH_LEN  = 32'd4;
  localparam logic [31:0] HASH_F1   = 32'h85ebca6b;
  localparam logic [31:0] HASH_F2   = 32'hc2b2ae35;
  localparam logic [31:0] COUNT_MAX = '1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_KEY1,
    ST_KEY2,
    ST_HASH1,
    ST_HASH2,
    ST_HASH3,
    ST_READ,
    ST_UPDATE,
    ST_DONE
  } cms_state_t;

endpackage

`default_nettype wire

@@ rtl/core/cms_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/count_min_sketch.sv @@
// Top level of the count-min sketch: sequencer, shared multiplier and counter store.
`default_nettype none

// Count-min sketch over 32-bit keys with ROWS banks of 2^COLUMN_BITS 32-bit
// counters held in one RAM. After reset the block clears all ROWS << COLUMN_BITS
// words of the RAM (4096 at the defaults), one word a cycle, with in_tready
// low; configuration writes are taken throughout. After an add or estimate is
// accepted, in_tready stays low until its last row has been updated and, for
// an estimate, until its result has been loaded into the output register,
// which waits while the previous result there is not taken with out_tready; an
// add of zero is accepted without leaving idle. The rate is set by the single
// 32x32 multiplier, which forms the two key products once per item and three
// hash products per row, and by the one read and one write port of the counter RAM.
module count_min_sketch #(
  parameter int ROWS        = cms_pkg::ROWS_DEFAULT,
  parameter int COLUMN_BITS = cms_pkg::COLUMN_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] key, [63:32] value
  input  wire logic        in_tuser,   // func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // [31:0] count_estimate
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);
  import cms_pkg::*;

  localparam int DEPTH = ROWS << COLUMN_BITS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RCW   = $clog2(ROWS + 1);

  cms_state_t state_r, state_nxt;

  logic [3:0]         index_bits_r;
  logic [2:0]         rows_in_use_r;
  logic [KEY_W-1:0]   key_r;
  logic [COUNT_W-1:0] value_r;
  logic               func_r;
  logic [31:0]        h_r;
  logic [31:0]        k_r;
  logic [RCW-1:0]     row_r;
  logic [AW-1:0]      addr_r;
  logic [AW-1:0]      clr_r;
  logic [COUNT_W-1:0] best_r;
  logic [COUNT_W-1:0] out_data_r;
  logic               out_valid_r;

  logic [RCW-1:0]         rows_live;
  logic [COLUMN_BITS-1:0] col_mask;
  logic [31:0]            mul_a, mul_b, product;
  logic [31:0]            t_add, t_mix, h_fin;
  logic [AW-1:0]          addr_nxt;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [COUNT_W-1:0]     ram_wdata, ram_rdata;
  logic                   in_fire, out_load, row_last, clear_last;

  // Out-of-range register values are clamped to the legal range.
  always_comb begin
    if (rows_in_use_r == 3'd0) begin
      rows_live = RCW'(1);
    end else if (32'(rows_in_use_r) > ROWS) begin
      rows_live = RCW'(ROWS);
    end else begin
      rows_live = RCW'(rows_in_use_r);
    end
    for (int i = 0; i < COLUMN_BITS; i++) begin
      col_mask[i] = (i == 0) || (32'(index_bits_r) > i);
    end
  end

  // Shared multiplier; the operands follow the hash step in progress.
  always_comb begin
    t_add = (h_r + HASH_N) ^ HASH_LEN;
    t_mix = t_add ^ (t_add >> 16);
    case (state_r)
      ST_KEY1: begin
        mul_a = key_r;
        mul_b = HASH_C1;
      end
      ST_KEY2: begin
        mul_a = {h_r[16:0], h_r[31:17]};
        mul_b = HASH_C2;
      end
      ST_HASH1: begin
        mul_a = {k_r[18:0], k_r[31:19]} ^ {32'(row_r) << 13 | 32'(row_r) >> 19};
        mul_b = HASH_M5;
      end
      ST_HASH2: begin
        mul_a = t_mix;
        mul_b = HASH_F1;
      end
      ST_HASH3: begin
        mul_a = h_r ^ (h_r >> 13);
        mul_b = HASH_F2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    product  = 32'(mul_a * mul_b);
    h_fin    = h_r ^ (h_r >> 16);
    addr_nxt = AW'((32'(row_r) << COLUMN_BITS) | 32'(h_fin[COLUMN_BITS-1:0] & col_mask));
  end

  assign in_fire    = in_tvalid && in_tready;
  assign row_last   = (row_r == RCW'(rows_live - 1'b1));
  assign clear_last = (clr_r == AW'(DEPTH - 1));
  assign out_load   = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign in_tready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid && !(in_tuser == FUNC_ADD && in_tdata[63:32] == '0)) begin
          state_nxt = ST_KEY1;
        end
      end
      ST_KEY1:  state_nxt = ST_KEY2;
      ST_KEY2:  state_nxt = ST_HASH1;
      ST_HASH1: state_nxt = ST_HASH2;
      ST_HASH2: state_nxt = ST_HASH3;
      ST_HASH3: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        if (!row_last) begin
          state_nxt = ST_HASH1;
        end else if (func_r == FUNC_ESTIMATE) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_bits_r  <= INDEX_BITS_RESET;
      rows_in_use_r <= ROWS_IN_USE_RESET;
      clr_r         <= '0;
      row_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INDEX_BITS:  index_bits_r  <= cfg_data;
          CFG_ROWS_IN_USE: rows_in_use_r <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (in_fire) begin
        row_r <= '0;
      end else if (state_r == ST_UPDATE && !row_last) begin
        row_r <= row_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r  <= in_tuser;
      key_r   <= in_tdata[31:0];
      value_r <= in_tdata[63:32];
      best_r  <= COUNT_MAX;
    end
    case (state_r)
      ST_KEY1, ST_HASH1, ST_HASH3: h_r <= product;
      ST_HASH2:                    h_r <= product;
      ST_KEY2:                     k_r <= product;
      ST_READ:                     addr_r <= addr_nxt;
      ST_UPDATE: begin
        if (ram_rdata < best_r) best_r <= ram_rdata;
      end
      default: ;
    endcase
    if (out_load) out_data_r <= best_r;
  end

  assign ram_we    = (state_r == ST_CLEAR) || (state_r == ST_UPDATE && func_r == FUNC_ADD);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_r : addr_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : ram_rdata + value_r;

  cms_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_counters (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_nxt),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_zero_add_skips : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == FUNC_ADD && in_tdata[63:32] == '0) |=> state_r == ST_IDLE)
    else $error("add of zero did not return to idle");

  a_estimate_no_write : assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r != ST_CLEAR) |-> func_r == FUNC_ADD)
    else $error("counter store written during an estimate");

  a_result_from_done : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside the done step");

  a_row_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |-> row_r < rows_live)
    else $error("row counter beyond active rows");
`endif

endmodule

`default_nettype wire
